>>> sv/agpg_pkg.sv
// shared types and constants for the affine grid point generator
package agpg_pkg;

   localparam int unsigned MaxDimDefault    = 4096;
   localparam int unsigned CoefCountDefault = 12;
   localparam int unsigned CsrAddrW         = 5;

   typedef enum logic [2:0] {
      CSR_MODE_3D  = 3'd0,
      CSR_ALIGN    = 3'd1,
      CSR_WIDTH    = 3'd2,
      CSR_HEIGHT   = 3'd3,
      CSR_DEPTH    = 3'd4
   } csr_idx_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_POINT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_DIV,
      ST_MAC,
      ST_ROUND,
      ST_DONE
   } state_type;

   // control from sequencer to divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

endpackage

>>> sv/agpg_divider.sv
// restoring serial divider, one quotient bit per cycle, rounds to nearest
module agpg_divider #(
   parameter int unsigned NumW = 31,
   parameter int unsigned DenW = 17
) (
   input  logic                   clock,
   input  logic                   reset,
   input  agpg_pkg::div_ctrl_type ctrl,
   input  logic                   num_neg,
   input  logic [NumW-1:0]        num_mag,
   input  logic [DenW-1:0]        den,
   output logic                   busy,
   output logic signed [NumW:0]   quot
);
   localparam int unsigned CntW = $clog2(NumW + 1);

   logic [NumW-1:0] q_ff, q_in;
   logic [DenW:0]   r_ff, r_in;
   logic [DenW-1:0] d_ff, d_in;
   logic            neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [DenW:0]   trial;
   logic [NumW:0]   rounded;
   logic [DenW:0]   twice_r;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {r_ff[DenW-1:0], q_ff[NumW-1]};
      if (ctrl.start) begin
         q_in    = num_mag;
         r_in    = '0;
         d_in    = den;
         neg_in  = num_neg;
         cnt_in  = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   // remainder*2 >= den rounds up, matching (mag + den/2)/den
   assign twice_r = {r_ff[DenW-1:0], 1'b0};
   assign rounded = {1'b0, q_ff} +
                    (NumW+1)'(twice_r >= {1'b0, d_ff} ? 1'b1 : 1'b0)
                    - (NumW+1)'((twice_r >= {1'b0, d_ff}) && d_ff[0] &&
                                (twice_r == {1'b0, d_ff}) ? 1'b1 : 1'b0);
   assign quot = neg_ff ? -$signed(rounded) : $signed(rounded);
   assign busy = busy_ff;

endmodule

>>> sv/agpg_mac.sv
// shared multiply-accumulate unit, one coefficient product per cycle
module agpg_mac (
   input  logic               clock,
   input  logic               clear,
   input  logic               acc_en,
   input  logic signed [31:0] coef,
   input  logic signed [31:0] coord,
   output logic signed [65:0] acc
);
   logic signed [63:0] prod_ff, prod_in;
   logic               prod_vld_ff;
   logic signed [65:0] acc_ff, acc_in;

   assign prod_in = coef * coord;

   always_comb begin
      acc_in = acc_ff;
      if (clear) acc_in = '0;
      else if (prod_vld_ff) acc_in = acc_ff + 66'(prod_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_vld_ff <= acc_en;
      acc_ff      <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> sv/affine_grid_point_generator.sv
// affine grid point generator top level: csr block, sequencer, divider and mac
// operation: a load request writes the coefficient store when it is taken; a point request runs
// a setup state and a serial division for each axis (the division is skipped for an aligned axis
// of size 1), a mac pass over 3 or 4 columns and a rounding step for each row, then a done state
// throughput: one request at a time; the next is taken the cycle after the result leaves
// synchronous active-high reset clears the state, output valid, configuration registers and the coefficient store
module affine_grid_point_generator #(
   parameter int unsigned MAX_DIM    = agpg_pkg::MaxDimDefault,
   parameter int unsigned COEF_COUNT = agpg_pkg::CoefCountDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[0], coef_index[4:1], coef_value[36:5], x[48:37], y[60:49], z[72:61]
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // grid_x[31:0], grid_y[63:32], grid_z[95:64]
   output logic [95:0]  rsp_tdata,
   // saturated
   output logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [agpg_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int unsigned DimW = $clog2(MAX_DIM + 1);
   localparam int unsigned IdxW = $clog2(COEF_COUNT);
   localparam int unsigned NumW = DimW + 1 + 16;

   // configuration registers
   logic        mode_ff, align_ff;
   logic [12:0] w_ff, h_ff, d_ff;
   logic        csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         align_ff <= 1'b0;
         w_ff     <= 13'd1;
         h_ff     <= 13'd1;
         d_ff     <= 13'd1;
      end else if (csr_wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[agpg_pkg::CsrAddrW-1:2])
            agpg_pkg::CSR_MODE_3D: mode_ff  <= csr_pwdata[0];
            agpg_pkg::CSR_ALIGN:   align_ff <= csr_pwdata[0];
            agpg_pkg::CSR_WIDTH:   w_ff     <= csr_pwdata[12:0];
            agpg_pkg::CSR_HEIGHT:  h_ff     <= csr_pwdata[12:0];
            agpg_pkg::CSR_DEPTH:   d_ff     <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[agpg_pkg::CsrAddrW-1:2])
         agpg_pkg::CSR_MODE_3D: csr_prdata = {31'd0, mode_ff};
         agpg_pkg::CSR_ALIGN:   csr_prdata = {31'd0, align_ff};
         agpg_pkg::CSR_WIDTH:   csr_prdata = {19'd0, w_ff};
         agpg_pkg::CSR_HEIGHT:  csr_prdata = {19'd0, h_ff};
         agpg_pkg::CSR_DEPTH:   csr_prdata = {19'd0, d_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // coefficient store, cleared on reset (COEF_COUNT entries in flops, twelve by default)
   logic [31:0] coef_ff [COEF_COUNT];

   // request fields
   logic        f_op;
   logic [3:0]  f_cidx;
   logic [31:0] f_cval;
   logic [11:0] f_idx [3];
   assign f_op     = req_tdata[0];
   assign f_cidx   = req_tdata[4:1];
   assign f_cval   = req_tdata[36:5];
   assign f_idx[0] = req_tdata[48:37];
   assign f_idx[1] = req_tdata[60:49];
   assign f_idx[2] = req_tdata[72:61];

   agpg_pkg::state_type state_ff, state_in;
   logic [11:0]        pidx_ff [3];
   logic [1:0]         axis_ff, axis_in;
   logic signed [31:0] crd_ff [4];
   logic [1:0]         row_ff, row_in;
   logic [2:0]         col_ff, col_in;
   logic [1:0]         drain_ff, drain_in;
   logic               sat_ff, sat_in;
   logic [95:0]        out_ff;
   logic               out_vld_ff, out_vld_in;
   logic               accept;

   assign req_tready = (state_ff == agpg_pkg::ST_IDLE) && !out_vld_ff;
   assign accept     = req_tvalid && req_tready;

   // effective axis size and divisor for the current axis
   logic [12:0]       raw_dim;
   logic [DimW-1:0]   dim;
   logic [DimW-1:0]   den;
   logic signed [DimW+1:0] num_i;
   logic              num_neg;
   logic [NumW-1:0]   num_mag;
   logic              one_align;

   always_comb begin
      case (axis_ff)
         2'd0:    raw_dim = w_ff;
         2'd1:    raw_dim = h_ff;
         default: raw_dim = d_ff;
      endcase
      if (raw_dim == 13'd0) dim = DimW'(1);
      else if (32'(raw_dim) > MAX_DIM) dim = DimW'(MAX_DIM);
      else dim = DimW'(raw_dim);
      den = align_ff ? dim - 1'b1 : dim;
      one_align = align_ff && (dim == DimW'(1));
      // align: 2i-(dim-1); else 2i+1-dim (the same value)
      num_i = $signed({1'b0, DimW'(pidx_ff[axis_ff]), 1'b0})
              - $signed({2'b0, dim}) + (DimW+2)'(1);
      num_neg = num_i[DimW+1];
      num_mag = {(num_neg ? (DimW+1)'(-num_i) : (DimW+1)'(num_i)), 16'd0};
   end

   agpg_pkg::div_ctrl_type div_ctrl;
   logic                   div_busy;
   logic signed [NumW:0]   div_q;

   agpg_divider #(.NumW(NumW), .DenW(DimW)) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (div_ctrl),
      .num_neg (num_neg),
      .num_mag (num_mag),
      .den     ((den == '0) ? DimW'(1) : den),
      .busy    (div_busy),
      .quot    (div_q)
   );

   // mac operands
   logic [2:0]         ncols;
   logic [IdxW-1:0]    caddr;
   logic               mac_clear, mac_en;
   logic signed [65:0] acc;
   assign ncols = mode_ff ? 3'd4 : 3'd3;
   assign caddr = IdxW'(row_ff) * IdxW'(ncols) + IdxW'(col_ff);

   agpg_mac u_mac (
      .clock  (clock),
      .clear  (mac_clear),
      .acc_en (mac_en),
      .coef   ($signed(coef_ff[caddr])),
      .coord  (crd_ff[col_ff[1:0]]),
      .acc    (acc)
   );

   // round Q34.32 to Q16.16, ties away from zero, then saturate
   logic [65:0]        acc_mag;
   logic [49:0]        r_mag;
   logic signed [50:0] r_val;
   logic [31:0]        r_sat;
   logic               r_clip;
   always_comb begin
      acc_mag = acc[65] ? 66'(-acc) : acc;
      r_mag   = 50'((acc_mag + 66'd32768) >> 16);
      r_val   = acc[65] ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
      r_clip  = 1'b0;
      r_sat   = r_val[31:0];
      if (r_val > 51'sd2147483647) begin
         r_sat = 32'h7fffffff; r_clip = 1'b1;
      end else if (r_val < -51'sd2147483648) begin
         r_sat = 32'h80000000; r_clip = 1'b1;
      end
   end

   // next state
   logic [1:0] n_axes, n_rows;
   assign n_axes = mode_ff ? 2'd3 : 2'd2;
   assign n_rows = mode_ff ? 2'd3 : 2'd2;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         agpg_pkg::ST_IDLE:
            if (accept && f_op == agpg_pkg::OP_POINT) state_in = agpg_pkg::ST_NORM;
         agpg_pkg::ST_NORM:
            if (!one_align) state_in = agpg_pkg::ST_DIV;
            else if (axis_ff == n_axes - 1'b1) state_in = agpg_pkg::ST_MAC;
         agpg_pkg::ST_DIV:
            if (!div_busy) state_in = (axis_ff == n_axes - 1'b1) ?
                                      agpg_pkg::ST_MAC : agpg_pkg::ST_NORM;
         agpg_pkg::ST_MAC:
            if (col_ff == ncols - 1'b1) state_in = agpg_pkg::ST_ROUND;
         agpg_pkg::ST_ROUND:
            if (drain_ff == 2'd1)
               state_in = (row_ff == n_rows - 1'b1) ? agpg_pkg::ST_DONE
                                                    : agpg_pkg::ST_MAC;
         agpg_pkg::ST_DONE:
            state_in = agpg_pkg::ST_IDLE;
         default: state_in = agpg_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      axis_in    = axis_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      drain_in   = drain_ff;
      sat_in     = sat_ff;
      out_vld_in = out_vld_ff;
      div_ctrl.start = 1'b0;
      mac_clear  = 1'b0;
      mac_en     = 1'b0;
      if (rsp_tvalid && rsp_tready) out_vld_in = 1'b0;
      unique case (state_ff)
         agpg_pkg::ST_IDLE: begin
            axis_in = '0; row_in = '0; col_in = '0;
            // flag belongs to the waiting result until a new request comes in
            if (accept) sat_in = 1'b0;
            mac_clear = 1'b1;
         end
         agpg_pkg::ST_NORM: begin
            div_ctrl.start = !one_align;
            if (one_align) axis_in = axis_ff + 1'b1;
         end
         agpg_pkg::ST_DIV:
            if (!div_busy) axis_in = axis_ff + 1'b1;
         agpg_pkg::ST_MAC: begin
            mac_en = 1'b1;
            col_in = col_ff + 1'b1;
            drain_in = 2'd0;
         end
         agpg_pkg::ST_ROUND: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 2'd1) begin
               sat_in = sat_ff | r_clip;
               col_in = '0;
               row_in = row_ff + 1'b1;
               mac_clear = 1'b1;
            end
         end
         agpg_pkg::ST_DONE: out_vld_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= agpg_pkg::ST_IDLE;
         out_vld_ff <= 1'b0;
         for (int k = 0; k < COEF_COUNT; k++) coef_ff[k] <= '0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         if (accept && f_op == agpg_pkg::OP_LOAD && 32'(f_cidx) < COEF_COUNT)
            coef_ff[IdxW'(f_cidx)] <= f_cval;
      end
      axis_ff  <= axis_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      drain_ff <= drain_in;
      sat_ff   <= sat_in;
      if (accept) begin
         pidx_ff[0] <= f_idx[0];
         pidx_ff[1] <= f_idx[1];
         pidx_ff[2] <= f_idx[2];
         crd_ff[0]  <= 32'sd65536;
         crd_ff[1]  <= 32'sd65536;
         crd_ff[2]  <= 32'sd65536;
         crd_ff[3]  <= 32'sd65536;
      end
      if (state_ff == agpg_pkg::ST_NORM && one_align)
         crd_ff[axis_ff] <= -32'sd65536;
      if (state_ff == agpg_pkg::ST_DIV && !div_busy)
         crd_ff[axis_ff] <= 32'(div_q);
      if (accept) out_ff[95:64] <= '0;
      if (state_ff == agpg_pkg::ST_ROUND && drain_ff == 2'd1) begin
         case (row_ff)
            2'd0:    out_ff[31:0]  <= r_sat;
            2'd1:    out_ff[63:32] <= r_sat;
            default: out_ff[95:64] <= r_sat;
         endcase
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = sat_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != agpg_pkg::ST_IDLE |-> !req_tready)
      else $error("request taken while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == agpg_pkg::ST_DONE |=> rsp_tvalid)
      else $error("result not shown after done");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

endmodule
